// ===== src/ray_sphere_intersect_defines.svh =====
`ifndef RAY_SPHERE_INTERSECT_DEFINES_SVH
`define RAY_SPHERE_INTERSECT_DEFINES_SVH
// assertion helpers used by the top-level intersector module
`define RSI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RSI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/rsi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rsi_pkg;
   localparam int unsigned CFG_IDX_BITS = 3;
   localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = 3'd0;
   localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = 3'd1;
   localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Z = 3'd2;
   localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS   = 3'd3;
   localparam logic [CFG_IDX_BITS-1:0] REG_MATERIAL = 3'd4;
   localparam int unsigned MAT_BITS = 8;
endpackage
`default_nettype wire

// ===== src/rsi_qdiv.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage: q = n*2^F / d,
// truncated toward zero, saturated to W bits. Payload SIDE rides along.
module rsi_qdiv #(
   parameter int W = 24,
   parameter int F = 16,
   parameter int SIDE = 1
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire logic            in_valid,
   input  wire logic signed [W-1:0] in_num,
   input  wire logic signed [W-1:0] in_den,
   input  wire logic [SIDE-1:0] in_side,
   output logic                 out_valid,
   output logic signed [W-1:0]  out_quot,
   output logic [SIDE-1:0]      out_side
);
   localparam int NB = W + F;          // dividend bits
   localparam int QB = W + F;          // quotient bits computed
   localparam int S  = QB;

   logic [S:0]         v_ff;
   logic [NB-1:0]      n_ff   [S+1];
   logic [W:0]         r_ff   [S+1];
   logic [QB-1:0]      q_ff   [S+1];
   logic [W-1:0]       d_ff   [S+1];
   logic               neg_ff [S+1];
   logic               dz_ff  [S+1];
   logic               nz_ff  [S+1];
   logic [SIDE-1:0]    sd_ff  [S+1];

   logic [W-1:0] un, ud;
   assign un = in_num[W-1] ? W'(-in_num) : in_num;
   assign ud = in_den[W-1] ? W'(-in_den) : in_den;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (advance) v_ff <= {v_ff[S-1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         n_ff[0]   <= {un, F'(0)};
         r_ff[0]   <= '0;
         q_ff[0]   <= '0;
         d_ff[0]   <= ud;
         neg_ff[0] <= in_num[W-1] ^ in_den[W-1];
         dz_ff[0]  <= (in_den == '0);
         nz_ff[0]  <= (in_num == '0);
         sd_ff[0]  <= in_side;
      end
   end

   for (genvar k = 0; k < S; k++) begin : g_step
      logic [W+1:0] rs, diff;
      assign rs   = {r_ff[k], n_ff[k][NB-1-k]};
      assign diff = rs - {2'b00, d_ff[k]};
      always_ff @(posedge clock) begin
         if (advance) begin
            n_ff[k+1]   <= n_ff[k];
            d_ff[k+1]   <= d_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            dz_ff[k+1]  <= dz_ff[k];
            nz_ff[k+1]  <= nz_ff[k];
            sd_ff[k+1]  <= sd_ff[k];
            if (!diff[W+1]) begin
               r_ff[k+1] <= diff[W:0];
               q_ff[k+1] <= q_ff[k] | (QB'(1) << (QB-1-k));
            end else begin
               r_ff[k+1] <= rs[W:0];
               q_ff[k+1] <= q_ff[k];
            end
         end
      end
   end

   logic [QB:0] lim;
   logic [QB-1:0] qm;
   always_comb begin
      lim = neg_ff[S] ? (QB+1)'(1) << (W-1) : ((QB+1)'(1) << (W-1)) - 1'b1;
      qm  = q_ff[S];
      if (dz_ff[S]) begin
         if (nz_ff[S]) out_quot = '0;
         else out_quot = neg_ff[S] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else if ({1'b0, qm} > lim) begin
         out_quot = neg_ff[S] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         out_quot = neg_ff[S] ? W'(-qm) : qm[W-1:0];
      end
   end
   assign out_valid = v_ff[S];
   assign out_side  = sd_ff[S];
endmodule
`default_nettype wire

// ===== src/rsi_qsqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipelined bit-by-bit square root: floor(sqrt(x*2^F)), zero for x <= 0.
module rsi_qsqrt #(
   parameter int W = 24,
   parameter int F = 16,
   parameter int SIDE = 1
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire logic            in_valid,
   input  wire logic signed [W-1:0] in_x,
   input  wire logic [SIDE-1:0] in_side,
   output logic                 out_valid,
   output logic signed [W-1:0]  out_root,
   output logic [SIDE-1:0]      out_side
);
   localparam int VB = W + F;
   localparam int RB = (VB + 1) / 2;
   localparam int S  = RB;

   logic [S:0]      v_ff;
   logic [VB-1:0]   x_ff  [S+1];
   logic [RB-1:0]   r_ff  [S+1];
   logic [SIDE-1:0] sd_ff [S+1];

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (advance) v_ff <= {v_ff[S-1:0], in_valid};
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]  <= (in_x[W-1] || in_x == '0) ? '0 : {in_x, F'(0)};
         r_ff[0]  <= '0;
         sd_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < S; k++) begin : g_step
      logic [RB-1:0] cand;
      logic [2*RB-1:0] sq;
      assign cand = r_ff[k] | (RB'(1) << (RB-1-k));
      assign sq   = cand * cand;
      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[k+1]  <= x_ff[k];
            sd_ff[k+1] <= sd_ff[k];
            r_ff[k+1]  <= (sq <= (2*RB)'(x_ff[k])) ? cand : r_ff[k];
         end
      end
   end

   always_comb begin
      if (RB >= W && r_ff[S] > RB'({1'b0, {(W-1){1'b1}}}))
         out_root = {1'b0, {(W-1){1'b1}}};
      else
         out_root = W'(r_ff[S]);
   end
   assign out_valid = v_ff[S];
   assign out_side  = sd_ff[S];
endmodule
`default_nettype wire

// ===== src/ray_sphere_intersect.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Ray/sphere intersector, fully pipelined: one ray beat per cycle in while
// the result side does not stall, one result beat per ray out, in order.
// From the accepting edge to the result beat a ray passes through four
// multiply/add stages, the square-root pipeline, the near and far root
// dividers side by side, root select, t*d, point, the three normal dividers
// side by side and the output register. A stall on the result side freezes
// the whole pipe; an output register holds the last result. Write the sphere
// registers only while the pipe is empty.
`include "ray_sphere_intersect_defines.svh"
module ray_sphere_intersect #(
   parameter int WORD_BITS = 24,
   parameter int FRAC_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_write,
   input  wire logic [rsi_pkg::CFG_IDX_BITS-1:0] csr_index,
   input  wire logic [WORD_BITS-1:0] csr_data,
   input  wire logic req_valid,
   output logic      req_stall,
   input  wire logic signed [WORD_BITS-1:0] req_origin_x,
   input  wire logic signed [WORD_BITS-1:0] req_origin_y,
   input  wire logic signed [WORD_BITS-1:0] req_origin_z,
   input  wire logic signed [WORD_BITS-1:0] req_dir_x,
   input  wire logic signed [WORD_BITS-1:0] req_dir_y,
   input  wire logic signed [WORD_BITS-1:0] req_dir_z,
   input  wire logic signed [WORD_BITS-1:0] req_t_min,
   input  wire logic signed [WORD_BITS-1:0] req_t_max,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output logic      rsp_hit,
   output logic signed [WORD_BITS-1:0] rsp_hit_t,
   output logic signed [WORD_BITS-1:0] rsp_point_x,
   output logic signed [WORD_BITS-1:0] rsp_point_y,
   output logic signed [WORD_BITS-1:0] rsp_point_z,
   output logic signed [WORD_BITS-1:0] rsp_normal_x,
   output logic signed [WORD_BITS-1:0] rsp_normal_y,
   output logic signed [WORD_BITS-1:0] rsp_normal_z,
   output logic [rsi_pkg::MAT_BITS-1:0] rsp_hit_material
);
   localparam int W = WORD_BITS;
   localparam int F = FRAC_BITS;
   localparam int PW = 2 * W;
   localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

   function automatic logic signed [W-1:0] sat(input logic signed [W+1:0] v);
      if (v > (W+2)'(MAXV)) return MAXV;
      if (v < (W+2)'(MINV)) return MINV;
      return v[W-1:0];
   endfunction
   function automatic logic signed [W-1:0] qadd(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
      return sat((W+2)'(a) + (W+2)'(b));
   endfunction
   function automatic logic signed [W-1:0] qsub(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
      return sat((W+2)'(a) - (W+2)'(b));
   endfunction
   // magnitude product, truncated toward zero, saturated
   function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
      logic [W-1:0] ma, mb;
      logic [PW-1:0] p, q;
      logic neg;
      logic [PW-1:0] lim;
      ma = a[W-1] ? W'(-a) : a;
      mb = b[W-1] ? W'(-b) : b;
      p = PW'(ma) * PW'(mb);
      q = p >> F;
      neg = a[W-1] ^ b[W-1];
      lim = neg ? PW'(1) << (W-1) : (PW'(1) << (W-1)) - 1'b1;
      if (q > lim) q = lim;
      return neg ? W'(-q) : q[W-1:0];
   endfunction

   logic signed [W-1:0] cx_ff, cy_ff, cz_ff;
   logic [W-2:0] rad_ff;
   logic [rsi_pkg::MAT_BITS-1:0] mat_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0; cy_ff <= '0; cz_ff <= '0;
         rad_ff <= (W-1)'(1) << F;
         mat_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            rsi_pkg::REG_CENTER_X: cx_ff <= csr_data;
            rsi_pkg::REG_CENTER_Y: cy_ff <= csr_data;
            rsi_pkg::REG_CENTER_Z: cz_ff <= csr_data;
            rsi_pkg::REG_RADIUS:   rad_ff <= csr_data[W-2:0];
            rsi_pkg::REG_MATERIAL: mat_ff <= csr_data[rsi_pkg::MAT_BITS-1:0];
            default: ;
         endcase
      end
   end
   logic signed [W-1:0] rads;
   assign rads = {1'b0, rad_ff};

   // whole pipe advances together; output register frees on take
   logic adv;
   assign adv = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // ---- stage 1: oc, the origin minus the center per component
   typedef struct packed {
      logic signed [W-1:0] ox, oy, oz, dx, dy, dz, tmin, tmax;
   } ray_type;
   ray_type r0, r1_ff, r2_ff, r3_ff;
   assign r0 = '{req_origin_x, req_origin_y, req_origin_z,
                 req_dir_x, req_dir_y, req_dir_z, req_t_min, req_t_max};
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [W-1:0] ocx1_ff, ocy1_ff, ocz1_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         r1_ff <= r0;
         ocx1_ff <= qsub(req_origin_x, cx_ff);
         ocy1_ff <= qsub(req_origin_y, cy_ff);
         ocz1_ff <= qsub(req_origin_z, cz_ff);
      end
   end
   // ---- stage 2: the ten products, radius squared among them
   logic signed [W-1:0] aa_ff [3], bb_ff [3], cc_ff [3], rr2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         r2_ff <= r1_ff;
         aa_ff[0] <= qmul(r1_ff.dx, r1_ff.dx);
         aa_ff[1] <= qmul(r1_ff.dy, r1_ff.dy);
         aa_ff[2] <= qmul(r1_ff.dz, r1_ff.dz);
         bb_ff[0] <= qmul(ocx1_ff, r1_ff.dx);
         bb_ff[1] <= qmul(ocy1_ff, r1_ff.dy);
         bb_ff[2] <= qmul(ocz1_ff, r1_ff.dz);
         cc_ff[0] <= qmul(ocx1_ff, ocx1_ff);
         cc_ff[1] <= qmul(ocy1_ff, ocy1_ff);
         cc_ff[2] <= qmul(ocz1_ff, ocz1_ff);
         rr2_ff   <= qmul(rads, rads);
      end
   end
   // ---- stage 3: dot sums, c
   logic signed [W-1:0] a3_ff, b3_ff, c3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         r3_ff <= r2_ff;
         a3_ff <= qadd(qadd(aa_ff[0], aa_ff[1]), aa_ff[2]);
         b3_ff <= qadd(qadd(bb_ff[0], bb_ff[1]), bb_ff[2]);
         c3_ff <= qsub(qadd(qadd(cc_ff[0], cc_ff[1]), cc_ff[2]), rr2_ff);
      end
   end
   // ---- stage 4: b*b and a*c
   ray_type r4_ff;
   logic signed [W-1:0] a4_ff, b4_ff, bsq4_ff, ac4_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         r4_ff <= r3_ff; a4_ff <= a3_ff; b4_ff <= b3_ff;
         bsq4_ff <= qmul(b3_ff, b3_ff);
         ac4_ff  <= qmul(a3_ff, c3_ff);
      end
   end
   logic signed [W-1:0] disc4;
   assign disc4 = qsub(bsq4_ff, ac4_ff);

   // ---- sqrt pipe
   localparam int RAYB = $bits(ray_type);
   localparam int SQS = RAYB + 2 * W + 1;
   logic [SQS-1:0] sq_in, sq_out;
   logic sq_v;
   logic signed [W-1:0] sq_root;
   assign sq_in = {r4_ff, a4_ff, b4_ff, (a4_ff != '0) && !disc4[W-1] && (disc4 != '0)};
   rsi_qsqrt #(.W(W), .F(F), .SIDE(SQS)) u_sqrt (
      .clock(clock), .reset(reset), .advance(adv),
      .in_valid(v4_ff), .in_x(disc4), .in_side(sq_in),
      .out_valid(sq_v), .out_root(sq_root), .out_side(sq_out));
   ray_type r5;
   logic signed [W-1:0] a5, b5, nb5;
   logic ok5;
   assign {r5, a5, b5, ok5} = sq_out;
   assign nb5 = sat(-(W+2)'(b5));

   // ---- both roots divided in parallel; ray rides the near lane, flag the far
   logic [RAYB-1:0] dn_out;
   logic df_out;
   logic dn_v, df_v;
   logic signed [W-1:0] tn, tf;
   rsi_qdiv #(.W(W), .F(F), .SIDE(RAYB)) u_div_near (
      .clock(clock), .reset(reset), .advance(adv),
      .in_valid(sq_v), .in_num(qsub(nb5, sq_root)), .in_den(a5), .in_side(r5),
      .out_valid(dn_v), .out_quot(tn), .out_side(dn_out));
   rsi_qdiv #(.W(W), .F(F), .SIDE(1)) u_div_far (
      .clock(clock), .reset(reset), .advance(adv),
      .in_valid(sq_v), .in_num(qadd(nb5, sq_root)), .in_den(a5), .in_side(ok5),
      .out_valid(df_v), .out_quot(tf), .out_side(df_out));

   ray_type r6;
   logic ok6, in_n, in_f;
   assign r6 = dn_out;
   assign ok6 = df_out;
   assign in_n = (tn > r6.tmin) && (tn < r6.tmax);
   assign in_f = (tf > r6.tmin) && (tf < r6.tmax);

   // ---- stage 6: pick root
   logic v6_ff, hit6_ff;
   logic signed [W-1:0] t6_ff;
   ray_type r6_ff;
   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (adv) v6_ff <= dn_v;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         hit6_ff <= ok6 && (in_n || in_f);
         t6_ff <= in_n ? tn : tf;
         r6_ff <= r6;
      end
   end
   // ---- stage 7: t*d
   logic v7_ff, hit7_ff;
   logic signed [W-1:0] t7_ff, pm_ff [3];
   ray_type r7_ff;
   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else if (adv) v7_ff <= v6_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         hit7_ff <= hit6_ff;
         t7_ff <= t6_ff;
         r7_ff <= r6_ff;
         pm_ff[0] <= qmul(t6_ff, r6_ff.dx);
         pm_ff[1] <= qmul(t6_ff, r6_ff.dy);
         pm_ff[2] <= qmul(t6_ff, r6_ff.dz);
      end
   end
   // ---- stage 8: point, point - center
   logic v8_ff, hit8_ff;
   logic signed [W-1:0] t8_ff, p8_ff [3], pc8_ff [3];
   logic signed [W-1:0] px, py, pz;
   assign px = qadd(pm_ff[0], r7_ff.ox);
   assign py = qadd(pm_ff[1], r7_ff.oy);
   assign pz = qadd(pm_ff[2], r7_ff.oz);
   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else if (adv) v8_ff <= v7_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         hit8_ff <= hit7_ff; t8_ff <= t7_ff;
         p8_ff[0] <= px; p8_ff[1] <= py; p8_ff[2] <= pz;
         pc8_ff[0] <= qsub(px, cx_ff);
         pc8_ff[1] <= qsub(py, cy_ff);
         pc8_ff[2] <= qsub(pz, cz_ff);
      end
   end
   // ---- normal dividers; hit, t and the point are spread over their lanes
   logic [W:0] nx_out;
   logic [2*W-1:0] ny_out;
   logic [W-1:0] nz_out;
   logic nx_v, ny_v, nz_v;
   logic signed [W-1:0] nxq, nyq, nzq;
   rsi_qdiv #(.W(W), .F(F), .SIDE(W+1)) u_div_nx (
      .clock(clock), .reset(reset), .advance(adv),
      .in_valid(v8_ff), .in_num(pc8_ff[0]), .in_den(rads), .in_side({hit8_ff, t8_ff}),
      .out_valid(nx_v), .out_quot(nxq), .out_side(nx_out));
   rsi_qdiv #(.W(W), .F(F), .SIDE(2*W)) u_div_ny (
      .clock(clock), .reset(reset), .advance(adv),
      .in_valid(v8_ff), .in_num(pc8_ff[1]), .in_den(rads),
      .in_side({p8_ff[0], p8_ff[1]}),
      .out_valid(ny_v), .out_quot(nyq), .out_side(ny_out));
   rsi_qdiv #(.W(W), .F(F), .SIDE(W)) u_div_nz (
      .clock(clock), .reset(reset), .advance(adv),
      .in_valid(v8_ff), .in_num(pc8_ff[2]), .in_den(rads), .in_side(p8_ff[2]),
      .out_valid(nz_v), .out_quot(nzq), .out_side(nz_out));

   logic hitn;
   logic signed [W-1:0] tn9, pxn, pyn, pzn;
   assign {hitn, tn9} = nx_out;
   assign {pxn, pyn} = ny_out;
   assign pzn = nz_out;

   // ---- output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (adv) rsp_valid <= nx_v;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit          <= hitn;
         rsp_hit_t        <= hitn ? tn9 : '0;
         rsp_point_x      <= hitn ? pxn : '0;
         rsp_point_y      <= hitn ? pyn : '0;
         rsp_point_z      <= hitn ? pzn : '0;
         rsp_normal_x     <= hitn ? nxq : '0;
         rsp_normal_y     <= hitn ? nyq : '0;
         rsp_normal_z     <= hitn ? nzq : '0;
         rsp_hit_material <= hitn ? mat_ff : '0;
      end
   end

   `RSI_ASSERT_IMP(a_div_lockstep, clock, reset, 1'b1, (dn_v == df_v) && (nx_v == ny_v) && (nx_v == nz_v), "divider lanes out of step")
   `RSI_ASSERT_IMP(a_stall_hold, clock, reset, rsp_valid && rsp_stall, req_stall, "pipe advanced under stall")
   `RSI_ASSERT_NEXT(a_out_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_hit_t), "held result changed")
   `RSI_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, (rsp_hit_t == '0) && (rsp_hit_material == '0), "miss with nonzero fields")
endmodule
`default_nettype wire
